FILE: hw/rtl/clcd_pkg.sv
`timescale 1ns / 1ps

package clcd_pkg;

	// Expander byte bit positions
	localparam int unsigned BitSelect    = 0;
	localparam int unsigned BitRead      = 1;
	localparam int unsigned BitEnable    = 2;
	localparam int unsigned BitBacklight = 3;

	// Display address map
	localparam logic [6:0] Line1End   = 7'h28;
	localparam logic [6:0] Line2Start = 7'h40;
	localparam logic [6:0] Line2End   = 7'h68;
	localparam logic [5:0] FoldColumn = 6'd20;
	localparam logic [2:0] FoldRows   = 3'd4;

	// Nibble accumulator: marker bit plus two nibbles
	localparam logic [8:0] AccRestart = 9'h001;

	// Configuration register indexes and reset values
	localparam logic RegDisplayRows = 1'b0;
	localparam logic RegMaxColumns  = 1'b1;
	localparam logic [2:0] DisplayRowsReset = 3'd2;
	localparam logic [5:0] MaxColumnsReset  = 6'd40;
	localparam logic [5:0] ColumnLimit      = 6'd40;

	typedef enum logic [1:0] {
		EV_IGNORED  = 2'd0,
		EV_ABSORBED = 2'd1,
		EV_WRITE    = 2'd2,
		EV_CLEAR    = 2'd3
	} event_t;

endpackage

FILE: hw/rtl/char_lcd_backpack_emulator_unit.sv
`timescale 1ns / 1ps

// Character LCD backpack emulator. Each item is one byte written to the port
// expander behind a 4-bit character LCD; each item gives exactly one result
// item: an event code (ignored, absorbed, character write, clear), the row,
// column and code of a written character, the backlight state and the count
// of columns seen. One item is accepted per clock cycle while the result
// channel is not stalled; each result passes the input register, then the
// result register, and the decoder state (accumulator, address, column count)
// is updated as its item moves from the one to the other.
// display_rows and max_columns are written through the APB port at byte
// addresses 0 and 4 and should only change while no items are in flight.
module char_lcd_backpack_emulator_unit (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] bus_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_res,
	output logic [1:0] write_row,
	output logic [5:0] write_column,
	output logic [7:0] write_char,
	output logic       backlight_on,
	output logic [5:0] column_count,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [2:0] display_rows_q;
	logic [5:0] max_columns_q;

	// input stage
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       in_acc;
	logic       adv;

	// decoder state
	logic       select_q;
	logic [8:0] acc_q;
	logic [6:0] addr_q;
	logic [5:0] seen_q;
	logic       light_q;

	// next state and result
	logic       select_d;
	logic [8:0] acc_d;
	logic [6:0] addr_d;
	logic [5:0] seen_d;
	logic       light_d;
	clcd_pkg::event_t ev_d;
	logic [1:0] row_d;
	logic [5:0] col_d;
	logic [7:0] chr_d;

	// result register
	clcd_pkg::event_t ev_q;
	logic [1:0] row_q;
	logic [5:0] col_q;
	logic [7:0] chr_q;

	// scratch for the decode
	logic       counted;
	logic [8:0] acc_shift;
	logic [7:0] whole;
	logic [6:0] addr_fix;
	logic [5:0] x_raw;
	logic [5:0] x_fold;
	logic [1:0] y_fold;
	logic [5:0] grow;
	logic       cfg_wr;

	// Handshake
	assign adv      = v_s1 && (!out_valid || !out_stall);
	assign in_stall = v_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			clcd_pkg::RegDisplayRows: prdata = {29'd0, display_rows_q};
			clcd_pkg::RegMaxColumns:  prdata = {26'd0, max_columns_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_rows_q <= clcd_pkg::DisplayRowsReset;
			max_columns_q  <= clcd_pkg::MaxColumnsReset;
		end else if (cfg_wr) begin
			if (paddr[2] == clcd_pkg::RegDisplayRows) begin
				display_rows_q <= pwdata[2:0];
			end else begin
				max_columns_q <= pwdata[5:0];
			end
		end
	end

	// Input register: load on accept, drop once passed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= bus_byte;
		end
	end

	// Decode one expander byte against the current state
	always_comb begin
		select_d  = select_q;
		acc_d     = acc_q;
		addr_d    = addr_q;
		seen_d    = seen_q;
		light_d   = light_q;
		ev_d      = clcd_pkg::EV_IGNORED;
		row_d     = '0;
		col_d     = '0;
		chr_d     = '0;
		acc_shift = '0;
		whole     = '0;
		addr_fix  = addr_q;
		x_raw     = '0;
		x_fold    = '0;
		y_fold    = '0;
		grow      = '0;

		counted = byte_s1[clcd_pkg::BitEnable] && !byte_s1[clcd_pkg::BitRead];
		if (counted) begin
			light_d  = byte_s1[clcd_pkg::BitBacklight];
			select_d = byte_s1[clcd_pkg::BitSelect];
			// restart the accumulator on a select change, then take the nibble
			if (select_d != select_q) begin
				acc_shift = {clcd_pkg::AccRestart[4:0], byte_s1[7:4]};
			end else begin
				acc_shift = {acc_q[4:0], byte_s1[7:4]};
			end
			acc_d = acc_shift;
			ev_d  = clcd_pkg::EV_ABSORBED;
			whole = acc_shift[7:0];
			if (acc_shift[8]) begin
				acc_d = clcd_pkg::AccRestart;
				if (select_d) begin
					// character data: fix up the address, then fold
					if (addr_q >= clcd_pkg::Line2End) begin
						addr_fix = '0;
					end else if (addr_q >= clcd_pkg::Line1End &&
					             addr_q < clcd_pkg::Line2Start) begin
						addr_fix = clcd_pkg::Line2Start;
					end else begin
						addr_fix = addr_q;
					end
					x_raw = addr_fix[5:0];
					if (display_rows_q == clcd_pkg::FoldRows &&
					    x_raw >= clcd_pkg::FoldColumn) begin
						x_fold = x_raw - clcd_pkg::FoldColumn;
						y_fold = {1'b1, addr_fix[6]};
					end else begin
						x_fold = x_raw;
						y_fold = {1'b0, addr_fix[6]};
					end
					addr_d = addr_fix + 7'd1;
					grow   = x_fold + 6'd1;
					if (x_fold >= seen_q) begin
						seen_d = (grow < max_columns_q) ? grow : max_columns_q;
					end
					row_d = y_fold;
					col_d = x_fold;
					chr_d = whole;
					ev_d  = clcd_pkg::EV_WRITE;
				end else begin
					// command: decode by leading one
					if (whole[7]) begin
						addr_d = whole[6:0];
					end else if (whole[7:2] == 6'd0 && whole[1]) begin
						addr_d = '0;
					end else if (whole == 8'd1) begin
						addr_d = '0;
						ev_d   = clcd_pkg::EV_CLEAR;
					end
				end
			end
		end
	end

	// State update: advance with each item taken from the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q <= 1'b0;
			acc_q    <= clcd_pkg::AccRestart;
			addr_q   <= '0;
			seen_q   <= '0;
			light_q  <= 1'b0;
		end else if (adv) begin
			select_q <= select_d;
			acc_q    <= acc_d;
			addr_q   <= addr_d;
			seen_q   <= seen_d;
			light_q  <= light_d;
		end
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_q  <= ev_d;
			row_q <= row_d;
			col_q <= col_d;
			chr_q <= chr_d;
		end
	end

	assign event_res    = ev_q;
	assign write_row    = row_q;
	assign write_column = col_q;
	assign write_char   = chr_q;
	assign backlight_on = light_q;
	assign column_count = seen_q;

	// Assertions
	a_acc_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		!acc_q[8])
		else $error("accumulator kept a completed byte");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked item");

	a_write_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ev_q == clcd_pkg::EV_WRITE |-> col_q < clcd_pkg::ColumnLimit)
		else $error("written column out of range");

	a_nonwrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ev_q != clcd_pkg::EV_WRITE |-> chr_q == 8'd0 && col_q == 6'd0
		&& row_q == 2'd0)
		else $error("write fields set on a non-write result");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= clcd_pkg::ColumnLimit || seen_q == $past(seen_q))
		else $error("column count grew past the column limit");

endmodule
